// ===== src/oair_pkg.sv =====
package oair_pkg;

    // default store depth
    localparam int DEF_MAX_ENTRIES = 256;

    // fixed field widths
    localparam int CMD_W  = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== src/oair_ram.sv =====
module oair_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ordered_array_insert_remove.sv =====
// steps: append, write and errors go from the checks to the result load, a read
// waits in S_READ first, insert and remove run the move loop before the result load
// throughput: one request at a time; the next request is taken the cycle after
// the result register loads, which waits while an earlier result is not taken;
// entries move one per cycle through the single read and write port of the memory
// reset: synchronous active low, clears the entry count, the sequencer and the
// output valid; memory contents are not cleared and need no clearing pass
module ordered_array_insert_remove
    import oair_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int ADDR_W = $clog2(MAX_ENTRIES),
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1),
    localparam int IN_W   = ((CMD_W + CNT_W + VAL_W + 7) / 8) * 8,
    localparam int OUT_W  = ((VAL_W + STAT_W + CNT_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request: command, position, write_value
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    // result: read_value, status, entry_count
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [ADDR_W-1:0] ONE_ADR = ADDR_W'(1);

    // request fields
    logic [CMD_W-1:0] in_cmd;
    logic [CNT_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    assign in_cmd = i_s_tdata[CMD_W-1:0];
    assign in_pos = i_s_tdata[CMD_W +: CNT_W];
    assign in_val = i_s_tdata[CMD_W + CNT_W +: VAL_W];

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_insert, n_insert;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [ADDR_W-1:0] r_src, n_src;
    logic [ADDR_W-1:0] r_last, n_last;
    logic              r_issue, n_issue;
    logic              r_wpend, n_wpend;
    logic [ADDR_W-1:0] r_wdst, n_wdst;
    logic [VAL_W-1:0]  r_rd, n_rd;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic              r_m_tvalid, n_m_tvalid;
    logic [VAL_W-1:0]  r_out_rd, n_out_rd;
    logic [STAT_W-1:0] r_out_stat, n_out_stat;
    logic [CNT_W-1:0]  r_out_count, n_out_count;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic             accept;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] pos_p1;
    logic             full;
    logic             pos_lt_cnt;
    logic             pos_le_cnt;

    assign accept     = i_s_tvalid && o_s_tready;
    assign cnt_m1     = r_count - ONE_CNT;
    assign pos_p1     = in_pos + ONE_CNT;
    assign full       = (r_count == MAX_CNT);
    assign pos_lt_cnt = (in_pos < r_count);
    assign pos_le_cnt = (in_pos <= r_count);

    oair_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer: checks on request, then read wait, move loop or result load
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_insert    = r_insert;
        n_pos       = r_pos;
        n_val       = r_val;
        n_src       = r_src;
        n_last      = r_last;
        n_issue     = r_issue;
        n_wpend     = 1'b0;
        n_wdst      = r_wdst;
        n_rd        = r_rd;
        n_stat      = r_stat;
        n_m_tvalid  = r_m_tvalid;
        n_out_rd    = r_out_rd;
        n_out_stat  = r_out_stat;
        n_out_count = r_out_count;
        ram_we      = 1'b0;
        ram_waddr   = r_wdst;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_src;

        // result register drains independently of the sequencer
        if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rd      = '0;
                    n_stat    = ST_DONE;
                    n_val     = in_val;
                    n_pos     = in_pos[ADDR_W-1:0];
                    n_state   = S_RESP;
                    ram_raddr = in_pos[ADDR_W-1:0];
                    unique case (in_cmd)
                        CMD_APPEND: begin
                            if (full) begin
                                n_stat = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[ADDR_W-1:0];
                                ram_wdata = in_val;
                                n_count   = r_count + ONE_CNT;
                            end
                        end
                        CMD_INSERT: begin
                            if (!pos_le_cnt) begin
                                n_stat = ST_RANGE;
                            end else if (full) begin
                                n_stat = ST_FULL;
                            end else begin
                                n_insert = 1'b1;
                                n_src    = cnt_m1[ADDR_W-1:0];
                                n_last   = in_pos[ADDR_W-1:0];
                                n_issue  = (in_pos != r_count);
                                n_state  = S_SHIFT;
                            end
                        end
                        CMD_REMOVE: begin
                            if (!pos_lt_cnt) begin
                                n_stat = ST_RANGE;
                            end else begin
                                n_insert = 1'b0;
                                n_src    = pos_p1[ADDR_W-1:0];
                                n_last   = cnt_m1[ADDR_W-1:0];
                                n_issue  = (in_pos != cnt_m1);
                                n_state  = S_SHIFT;
                            end
                        end
                        CMD_READ: begin
                            if (!pos_lt_cnt) begin
                                n_stat = ST_RANGE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        CMD_WRITE: begin
                            if (!pos_lt_cnt) begin
                                n_stat = ST_RANGE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = in_pos[ADDR_W-1:0];
                                ram_wdata = in_val;
                            end
                        end
                        default: begin
                            n_stat = ST_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rd    = ram_rdata;
                n_state = S_RESP;
            end
            S_SHIFT: begin
                // write back the entry read in the previous cycle
                if (r_wpend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wdst;
                    ram_wdata = ram_rdata;
                end
                if (r_issue) begin
                    ram_raddr = r_src;
                    n_wpend   = 1'b1;
                    n_wdst    = r_insert ? (r_src + ONE_ADR) : (r_src - ONE_ADR);
                    if (r_src == r_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_src = r_insert ? (r_src - ONE_ADR) : (r_src + ONE_ADR);
                    end
                end else if (!r_wpend) begin
                    // moves done: place the new entry or shrink the list
                    if (r_insert) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pos;
                        ram_wdata = r_val;
                        n_count   = r_count + ONE_CNT;
                    end else begin
                        n_count   = cnt_m1;
                    end
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid  = 1'b1;
                    n_out_rd    = r_rd;
                    n_out_stat  = r_stat;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_issue    <= 1'b0;
            r_wpend    <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_issue    <= n_issue;
            r_wpend    <= n_wpend;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_insert    <= n_insert;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_src       <= n_src;
        r_last      <= n_last;
        r_wdst      <= n_wdst;
        r_rd        <= n_rd;
        r_stat      <= n_stat;
        r_out_rd    <= n_out_rd;
        r_out_stat  <= n_out_stat;
        r_out_count <= n_out_count;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = OUT_W'({r_out_count, r_out_stat, r_out_rd});

`ifndef SYNTHESIS
    // the count never runs past the store depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("entry count above capacity");

    // a request is taken once, then the block is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("ready right after a request");

    // a full report only comes with a full store
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_stat == ST_FULL) |-> (r_out_count == MAX_CNT))
        else $error("full status with free entries");

    // a memory move only happens inside the move loop
    a_move_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> (r_state == S_SHIFT))
        else $error("pending move outside the move loop");
`endif

endmodule
